/* rtl/sfr_pkg.sv */
// shared constants, types and register indexes for the stream find-and-replace block
package sfr_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int MAX_REPLACE = 8;
    localparam int OUT_DEPTH   = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int FILL_W     = $clog2(MAX_PATTERN + 1);
    localparam int RLEN_W     = $clog2(MAX_REPLACE + 1);
    localparam int COUNT_W    = $clog2(OUT_DEPTH + 1);

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES  = 2'd0,
        REG_PATTERN_LENGTH = 2'd1,
        REG_REPLACE_BYTES  = 2'd2,
        REG_REPLACE_LENGTH = 2'd3
    } reg_index_t;

    typedef logic [BYTE_W-1:0]            byte_t;
    typedef byte_t [MAX_PATTERN-1:0]      window_t;
    typedef byte_t [OUT_DEPTH-1:0]        out_bytes_t;

    // configuration as seen by the datapath, lengths already capped
    typedef struct packed {
        logic [MAX_PATTERN*BYTE_W-1:0] pat_bytes;
        logic [FILL_W-1:0]             pat_len;
        logic [MAX_REPLACE*BYTE_W-1:0] rep_bytes;
        logic [RLEN_W-1:0]             rep_len;
        logic                          flush;
    } cfg_t;

    // result burst for one input beat; count zero means no output
    typedef struct packed {
        out_bytes_t         bytes;
        logic [COUNT_W-1:0] count;
        logic               present;
    } result_t;

endpackage

/* rtl/sfr_cfg.sv */
// configuration registers with length capping
module sfr_cfg import sfr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [MAX_PATTERN*BYTE_W-1:0] pat_bytes_reg;
    logic [LEN_W-1:0]              pat_len_reg;
    logic [MAX_REPLACE*BYTE_W-1:0] rep_bytes_reg;
    logic [LEN_W-1:0]              rep_len_reg;
    reg_index_t                    idx;

    assign idx = reg_index_t'(cfg_index);

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
        end else if (cfg_we) begin
            unique case (idx)
                REG_PATTERN_BYTES:  pat_bytes_reg <= cfg_data[MAX_PATTERN*BYTE_W-1:0];
                REG_PATTERN_LENGTH: pat_len_reg   <= cfg_data[LEN_W-1:0];
                REG_REPLACE_BYTES:  rep_bytes_reg <= cfg_data[MAX_REPLACE*BYTE_W-1:0];
                REG_REPLACE_LENGTH: rep_len_reg   <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // capped lengths and window flush on a pattern length write
    always_comb begin
        cfg.pat_bytes = pat_bytes_reg;
        cfg.rep_bytes = rep_bytes_reg;
        cfg.pat_len   = (pat_len_reg > LEN_W'(MAX_PATTERN)) ? FILL_W'(MAX_PATTERN)
                                                            : FILL_W'(pat_len_reg);
        cfg.rep_len   = (rep_len_reg > LEN_W'(MAX_REPLACE)) ? RLEN_W'(MAX_REPLACE)
                                                            : RLEN_W'(rep_len_reg);
        cfg.flush     = cfg_we && (idx == REG_PATTERN_LENGTH);
    end

endmodule

/* rtl/sfr_window.sv */
// byte window, pattern compare and result burst build
module sfr_window import sfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        in_fire,
    input  byte_t       in_byte,
    input  logic        in_last,
    output result_t     res
);

    window_t           win_reg, win_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    window_t           ins;
    logic [FILL_W-1:0] fill_eff;
    logic [FILL_W-1:0] new_fill;
    logic              full;
    logic              match;

    // window with the new byte written at the fill position
    always_comb begin
        fill_eff = (fill_reg >= cfg.pat_len) ? '0 : fill_reg;
        new_fill = fill_eff + FILL_W'(1);
        full     = (new_fill == cfg.pat_len);
        for (int k = 0; k < MAX_PATTERN; k++) begin
            ins[k] = (FILL_W'(k) == fill_eff) ? in_byte : win_reg[k];
        end
    end

    // compare the valid part of the window against the pattern
    always_comb begin
        match = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if ((FILL_W'(k) < cfg.pat_len) && (ins[k] != cfg.pat_bytes[k*BYTE_W +: BYTE_W]))
                match = 1'b0;
        end
    end

    // result burst for this beat
    always_comb begin
        res.present = 1'b1;
        res.bytes   = '0;
        res.count   = '0;
        if (cfg.pat_len == '0) begin
            res.bytes[0] = in_byte;
            res.count    = COUNT_W'(1);
        end else if (full && match) begin
            for (int k = 0; k < MAX_REPLACE; k++)
                res.bytes[k] = cfg.rep_bytes[k*BYTE_W +: BYTE_W];
            res.count = COUNT_W'(cfg.rep_len);
        end else begin
            for (int k = 0; k < MAX_PATTERN; k++)
                res.bytes[k] = ins[k];
            if (in_last)
                res.count = COUNT_W'(new_fill);
            else if (full)
                res.count = COUNT_W'(1);
        end
        // empty closing beat when the final byte yields nothing
        if (in_last && (res.count == '0)) begin
            res.bytes   = '0;
            res.count   = COUNT_W'(1);
            res.present = 1'b0;
        end
    end

    // window update
    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (cfg.flush) begin
            fill_next = '0;
        end else if (in_fire) begin
            if (cfg.pat_len == '0) begin
                fill_next = '0;
            end else begin
                win_next  = ins;
                fill_next = new_fill;
                if (full && match) begin
                    fill_next = '0;
                end else if (full) begin
                    for (int k = 0; k < MAX_PATTERN - 1; k++)
                        win_next[k] = ins[k+1];
                    fill_next = cfg.pat_len - FILL_W'(1);
                end
                if (in_last)
                    fill_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

`ifndef SYNTHESIS
    // a final byte always leaves the window empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_last |=> fill_reg == '0)
        else $error("window not empty after final byte");

    // between beats the window holds fewer bytes than the pattern
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && !cfg.flush && (cfg.pat_len != '0) |=> fill_reg < $past(cfg.pat_len))
        else $error("window fill reached pattern length");
`endif

endmodule

/* rtl/sfr_outbuf.sv */
// result register that plays a burst out one beat at a time
module sfr_outbuf import sfr_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_fire,
    input  result_t res,
    output logic    in_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output byte_t   m_out_byte,
    output logic    m_byte_present,
    output logic    m_run_last
);

    out_bytes_t         bytes_reg, bytes_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               present_reg, present_next;
    logic               m_fire;

    assign m_valid        = (cnt_reg != '0);
    assign m_fire         = m_valid && m_ready;
    assign m_out_byte     = bytes_reg[0];
    assign m_byte_present = present_reg;
    assign m_run_last     = (cnt_reg == COUNT_W'(1));
    // take a new beat when the register is empty or while the last byte of the burst leaves
    assign in_ready       = (cnt_reg == '0) || (m_run_last && m_ready);

    // load a fresh burst or shift out one byte
    always_comb begin
        bytes_next   = bytes_reg;
        cnt_next     = cnt_reg;
        present_next = present_reg;
        if (in_fire && (res.count != '0)) begin
            bytes_next   = res.bytes;
            cnt_next     = res.count;
            present_next = res.present;
        end else if (m_fire) begin
            for (int k = 0; k < OUT_DEPTH - 1; k++)
                bytes_next[k] = bytes_reg[k+1];
            cnt_next = cnt_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg   <= bytes_next;
        present_reg <= present_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

`ifndef SYNTHESIS
    // an empty closing beat is always alone in its burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_present |-> m_run_last)
        else $error("empty beat inside a burst");

    // burst count never exceeds the buffer depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= COUNT_W'(OUT_DEPTH))
        else $error("burst count overflow");

    // a burst in flight only counts down until it ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && !m_run_last |=> cnt_reg == $past(cnt_reg) - COUNT_W'(1))
        else $error("burst count skipped");
`endif

endmodule

/* rtl/stream_find_replace.sv */
// top level of the streaming byte find-and-replace block
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_data_byte, s_end_of_text
//   m_       out        m_valid/m_ready    m_out_byte, m_byte_present, m_run_last
//   cfg_     in         cfg_we             cfg_index, cfg_data
//
// an input beat is compared and turned into its burst in the cycle it is taken;
// the burst leaves from the result register from the next cycle, one byte per cycle while m_ready is high.
// a beat that makes n output bytes (n up to 8) holds s_ready low until the last
// of them leaves; a beat that makes none loads nothing, so plain text without
// matches flows at one byte per cycle while m_ready is high.
// synchronous active-low reset empties the window and the result register.
// a stall on m_ holds the burst; s_ waits until the last byte of it leaves.
module stream_find_replace import sfr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_data_byte,
    input  logic                  s_end_of_text,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_out_byte,
    output logic                  m_byte_present,
    output logic                  m_run_last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t res;
    logic    s_fire;

    assign s_fire = s_valid && s_ready;

    // configuration registers
    sfr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // window and compare
    sfr_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_fire  (s_fire),
        .in_byte  (s_data_byte),
        .in_last  (s_end_of_text),
        .res      (res)
    );

    // result register
    sfr_outbuf u_outbuf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_fire        (s_fire),
        .res            (res),
        .in_ready       (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_present (m_byte_present),
        .m_run_last     (m_run_last)
    );

endmodule
